### design/chained_byte_mix_block_cipher_core_defines.svh
// Assertion macros used by the cipher core RTL
`ifndef CHAINED_BYTE_MIX_BLOCK_CIPHER_CORE_DEFINES_SVH
`define CHAINED_BYTE_MIX_BLOCK_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CBM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CBM_ASSERT_NEVER(label, clk, rst_n, cond) \
    `CBM_ASSERT(label, clk, rst_n, !(cond))
`else
`define CBM_ASSERT(label, clk, rst_n, prop)
`define CBM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

### design/cbm_pkg.sv
package cbm_pkg;

    localparam int BLOCK_W = 64;
    localparam int HALF_W  = BLOCK_W / 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] MIX_MUL_A = 8'd63;
    localparam logic [7:0] MIX_MUL_C = 8'd17;
    localparam logic [7:0] MIX_ADD_G = 8'd51;

    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KEY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_KEY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KEY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_ROUNDS = 2'd3;

    typedef logic [BLOCK_W-1:0] t_block;

    function automatic t_block swap_halves(input t_block v);
        return {v[HALF_W-1:0], v[BLOCK_W-1:HALF_W]};
    endfunction

endpackage

### design/cbm_mix.sv
module cbm_mix (
    input  cbm_pkg::t_block i_blk,
    output cbm_pkg::t_block o_blk
);
    import cbm_pkg::*;

    logic [7:0] b0, b1, b2, b3;
    logic [7:0] a, b, c, d, e, f, g;

    always_comb begin
        b0 = i_blk[7:0];
        b1 = i_blk[15:8];
        b2 = i_blk[23:16];
        b3 = i_blk[31:24];
        a  = 8'(b0 * MIX_MUL_A);
        b  = 8'(a + b3);
        c  = 8'(b1 * MIX_MUL_C);
        d  = 8'(c + b2);
        e  = 8'(d + b);
        f  = 8'(e * b3);
        g  = 8'(f + b + MIX_ADD_G);
        o_blk = i_blk ^ {g, g ^ e, d, b ^ d, 32'd0};
    end

endmodule

### design/chained_byte_mix_block_cipher_core.sv
// A block passes S_MIX1 (with extra rounds), S_MIX2 and S_HOLD before o_valid.
// Blocks are taken only in S_IDLE, never while one is in flight; the single shared
// byte-mix unit is used once per mix round and the chain value closes the loop.
// A waiting result stalls the next block only at its final output step.
// Reset (synchronous, active low): keys 0, extra rounds on, chain value 0, no result.
`include "chained_byte_mix_block_cipher_core_defines.svh"

module chained_byte_mix_block_cipher_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  cbm_pkg::t_block            i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  cbm_pkg::t_block            i_plain_block,
    input  logic                       i_first_block,
    input  logic                       i_last_block,
    output logic                       o_valid,
    input  logic                       i_ready,
    output cbm_pkg::t_block            o_cipher_block,
    output logic                       o_last_out
);
    import cbm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MIX1, S_MIX2, S_HOLD} t_state;

    t_state r_state;
    t_block r_outer_key, r_middle_key, r_inner_key;
    logic   r_extra_rounds;
    t_block r_chain;
    t_block r_blk;
    logic   r_last;
    logic   r_out_valid;
    t_block r_cipher;
    logic   r_last_out;

    t_block mix_out;
    t_block n_blk;
    logic   in_xfer;
    logic   out_free;

    cbm_mix u_mix (
        .i_blk (r_blk),
        .o_blk (mix_out)
    );

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_cipher_block = r_cipher;
    assign o_last_out     = r_last_out;
    assign in_xfer        = i_valid && o_ready;
    assign out_free       = !r_out_valid || i_ready;

    always_comb begin
        n_blk = i_plain_block ^ (i_first_block ? '0 : r_chain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_outer_key    <= '0;
            r_middle_key   <= '0;
            r_inner_key    <= '0;
            r_extra_rounds <= 1'b1;
            r_chain        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_OUTER_KEY:    r_outer_key    <= i_cfg_data;
                    REG_MIDDLE_KEY:   r_middle_key   <= i_cfg_data;
                    REG_INNER_KEY:    r_inner_key    <= i_cfg_data;
                    REG_EXTRA_ROUNDS: r_extra_rounds <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_last <= i_last_block;
                        if (r_extra_rounds) begin
                            r_blk   <= n_blk ^ r_inner_key;
                            r_state <= S_MIX1;
                        end else begin
                            r_blk   <= swap_halves(n_blk);
                            r_state <= S_MIX2;
                        end
                    end
                end
                S_MIX1: begin
                    r_blk   <= swap_halves(mix_out ^ r_middle_key);
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_blk   <= mix_out ^ r_outer_key;
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_cipher    <= r_blk;
                        r_last_out  <= r_last;
                        r_chain     <= r_last ? '0 : r_blk;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CBM_ASSERT(a_extra_path, i_clk, i_rst_n, in_xfer && r_extra_rounds |=> r_state == S_MIX1)
    `CBM_ASSERT(a_short_path, i_clk, i_rst_n, in_xfer && !r_extra_rounds |=> r_state == S_MIX2)
    `CBM_ASSERT(a_mix2_hold, i_clk, i_rst_n, r_state == S_MIX2 |=> r_state == S_HOLD)
    `CBM_ASSERT(a_chain_update, i_clk, i_rst_n,
        r_state == S_HOLD && out_free |=> r_out_valid && r_chain == (r_last_out ? '0 : r_cipher))
    `CBM_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n,
        r_state == S_HOLD && r_out_valid && !i_ready && $past(r_state) == S_IDLE)

endmodule
